// File: hw/rtl/gwpi_pkg.sv
package gwpi_pkg;

  // exponent for a^-1: every unit of GF(2^8)[x]/(x^4+1) has order dividing 1020
  localparam int unsigned EXP_BITS  = 10;
  localparam int unsigned BIT_IDX_W = 4;
  localparam logic [EXP_BITS-1:0] INV_EXP  = 10'd1019;
  localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(EXP_BITS - 1);

  localparam logic [7:0]  GF_POLY_LO = 8'h1B;  // x^8 + x^4 + x^3 + x + 1, low byte
  localparam logic [31:0] WORD_ONE   = 32'h0000_0001;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_e;

  // control into the shared coefficient unit
  typedef struct packed {
    logic       square;    // 1: base*base, 0: acc*base
    logic [1:0] coef_idx;  // output coefficient being formed
  } mul_ctrl_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = '0;
    x   = a;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) acc = acc ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ GF_POLY_LO) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

// File: hw/rtl/gf256_word_poly_inverse.sv
// Inverse of a word polynomial over GF(2^8) modulo x^4 + 1.
//
// Command channel: a word is taken on poly_word_i at a rising edge where
// start is high and busy is low. busy stays high until the result is out.
// Result channel: done_o is high for exactly one cycle with inverse_word_o
// and has_inverse_o valid; the receiver must take it in that cycle, there
// is no backpressure.
//
// The inverse is formed as a^1019 by square-and-multiply over a fixed
// 10-bit exponent. One shared coefficient unit (four GF(2^8) products and
// an XOR) builds one byte of a word product per cycle. 1019 has nine set
// bits: 9 multiplies and 9 squarings, then the result state. A word
// whose bytes XOR to zero has no inverse; done_o is high in the very next
// cycle with a zero result. One word is in flight at a time; the next
// word is taken only once the block is idle again.
//
// Reset (rst_ni low, async) returns the sequencer to idle; no result is
// pending after reset.
module gf256_word_poly_inverse import gwpi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] poly_word_i,
  output logic        done_o,
  output logic [31:0] inverse_word_o,
  output logic        has_inverse_o
);

  state_e state_q, state_d;

  logic [31:0]          acc_q, acc_d;
  logic [31:0]          base_q, base_d;
  logic [23:0]          prod_q, prod_d;      // low bytes of the product in progress
  logic [1:0]           coef_idx_q, coef_idx_d;
  logic [BIT_IDX_W-1:0] bit_idx_q, bit_idx_d;
  logic                 flag_q, flag_d;

  logic       accept;
  logic       at_one_zero;
  logic [7:0] coef;
  logic [31:0] prod_word;
  logic       last_coef;
  mul_ctrl_t  ctrl;

  assign accept      = start && !busy;
  // value at x = 1; zero means (x+1) divides the word, no inverse
  assign at_one_zero = (poly_word_i[7:0] ^ poly_word_i[15:8] ^
                        poly_word_i[23:16] ^ poly_word_i[31:24]) == 8'h00;
  assign last_coef   = coef_idx_q == 2'd3;
  assign prod_word   = {coef, prod_q};

  gwpi_coef_unit u_coef (
    .acc_i  (acc_q),
    .base_i (base_q),
    .ctrl_i (ctrl),
    .coef_o (coef)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (at_one_zero) state_d = ST_DONE;
          else             state_d = INV_EXP[0] ? ST_MUL : ST_SQR;
        end
      end
      ST_MUL: begin
        if (last_coef) state_d = (bit_idx_q == LAST_BIT) ? ST_DONE : ST_SQR;
      end
      ST_SQR: begin
        if (last_coef) begin
          state_d = INV_EXP[BIT_IDX_W'(bit_idx_q + 1'b1)] ? ST_MUL : ST_SQR;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and unit control
  always_comb begin
    busy          = 1'b1;
    done_o        = 1'b0;
    ctrl.square   = 1'b0;
    ctrl.coef_idx = coef_idx_q;
    case (state_q)
      ST_IDLE: busy        = 1'b0;
      ST_MUL:  ctrl.square = 1'b0;
      ST_SQR:  ctrl.square = 1'b1;
      ST_DONE: done_o      = 1'b1;
      default: busy        = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    acc_d      = acc_q;
    base_d     = base_q;
    prod_d     = prod_q;
    coef_idx_d = coef_idx_q;
    bit_idx_d  = bit_idx_q;
    flag_d     = flag_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          acc_d      = at_one_zero ? '0 : WORD_ONE;
          base_d     = poly_word_i;
          flag_d     = !at_one_zero;
          coef_idx_d = '0;
          bit_idx_d  = '0;
        end
      end
      ST_MUL, ST_SQR: begin
        coef_idx_d = coef_idx_q + 2'd1;
        if (!last_coef) begin
          prod_d[8*coef_idx_q +: 8] = coef;
        end else if (state_q == ST_MUL) begin
          acc_d = prod_word;
        end else begin
          base_d    = prod_word;
          bit_idx_d = BIT_IDX_W'(bit_idx_q + 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    base_q     <= base_d;
    prod_q     <= prod_d;
    coef_idx_q <= coef_idx_d;
    bit_idx_q  <= bit_idx_d;
    flag_q     <= flag_d;
  end

  assign inverse_word_o = acc_q;
  assign has_inverse_o  = flag_q;

  // a word without inverse reports zero
  a_zero_when_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !has_inverse_o |-> inverse_word_o == '0)
    else $error("non-invertible word reported a nonzero result");

  // an accepted word holds the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("block not busy after accepting a word");

  // one result cycle per word
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

  // squaring never runs past the last exponent bit
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_SQR) |-> bit_idx_q <= LAST_BIT)
    else $error("exponent bit index out of range");

endmodule

// File: hw/rtl/gwpi_coef_unit.sv
module gwpi_coef_unit import gwpi_pkg::*; (
  input  logic [31:0] acc_i,
  input  logic [31:0] base_i,
  input  mul_ctrl_t   ctrl_i,
  output logic [7:0]  coef_o
);

  logic [31:0] op_a;

  assign op_a = ctrl_i.square ? base_i : acc_i;

  // c[k] = sum_i a[i] * b[(k-i) mod 4], x^4 folds onto 1
  always_comb begin
    logic [1:0] j;
    coef_o = '0;
    for (int i = 0; i < 4; i++) begin
      j      = ctrl_i.coef_idx - 2'(i);
      coef_o = coef_o ^ gf_mul(op_a[8*i +: 8], base_i[8*j +: 8]);
    end
  end

endmodule
